[sv/bitbang_fpga_command_port_assert.svh]
// assertion macros used by the checker file
`ifndef BITBANG_FPGA_COMMAND_PORT_ASSERT_SVH
`define BITBANG_FPGA_COMMAND_PORT_ASSERT_SVH

// plain property, sampled on the rising clock, off while in reset
`define BBFCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication in the next cycle
`define BBFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bbfcp_pkg.sv]
package bbfcp_pkg;

  localparam int unsigned PARAM_ROM_DEPTH_DEF = 256;

  // command codes
  localparam logic [7:0] CMD_VERSION     = 8'h06;
  localparam logic [7:0] CMD_START_A     = 8'h0A;
  localparam logic [7:0] CMD_STATUS      = 8'h14;
  localparam logic [7:0] CMD_CH_B_OUT    = 8'h20;
  localparam logic [7:0] CMD_CH_A_IN     = 8'h21;
  localparam logic [7:0] CMD_CH_B_IN     = 8'h23;
  localparam logic [7:0] CMD_BRIGHT      = 8'h38;
  localparam logic [7:0] CMD_TOUCH       = 8'h41;
  localparam logic [7:0] CMD_PARAM_READ  = 8'h64;
  localparam logic [7:0] CMD_PARAM_SEEK  = 8'h65;
  localparam logic [7:0] CMD_PARAM_STEP  = 8'h66;
  localparam logic [7:0] CMD_START_B     = 8'h67;
  localparam logic [7:0] CMD_PARAM_FIRST = 8'h68;
  localparam logic [7:0] CMD_PARAM_LAST  = 8'h6E;
  localparam logic [7:0] CMD_CH_A_OUT    = 8'h70;

  // size tags of the parameter readout
  localparam logic [7:0] TAG_B3 = 8'hAA;
  localparam logic [7:0] TAG_B4 = 8'hA5;
  localparam logic [7:0] TAG_B5 = 8'h5A;
  localparam logic [7:0] TAG_NONE = 8'h55;

  localparam logic [7:0] READ_AFTER_WRITE = 8'hFF;

  localparam logic [1:0][7:0] VERSION_RST = {8'h32, 8'h14};
  localparam logic [1:0][7:0] STATUS_RST  = {8'hd5, 8'h07};

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       data_command_pin;
    logic       read_write_pin;
    logic       clock_now;
    logic       clock_before;
    logic       is_pin_data_register;
  } item_t;

  typedef struct packed {
    logic [7:0]      key;
    logic [7:0]      offset;
    logic [6:0][7:0] pbuf;
    logic [7:0]      start;
  } param_upd_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] addr);
    logic [7:0] v;
    unique case (addr)
      8'd43:   v = 8'h27;
      8'd47:   v = 8'hb8;
      8'd51:   v = 8'h20;
      8'd55:   v = 8'h21;
      8'd66:   v = 8'hea;
      8'd67:   v = 8'h60;
      8'd71:   v = 8'hdb;
      8'd83:   v = 8'h0d;
      8'd90:   v = 8'h7e;
      8'd91:   v = 8'haf;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[sv/bitbang_fpga_command_port.sv]
// Command port decoder for a pin-toggled byte bus. Each input item describes one
// write to the pin register; every item yields exactly one output item, the byte
// handed back to the bus. One item is accepted per clock cycle unless backpressure
// holds the input; an item waits in the input register, then the whole state update,
// including the parameter readout with its four rom fetches, checksum and scrambling,
// is done in one pass of logic into the result register, which drives the output.
// Backpressure on the output stalls both stages; the input stays ready while the
// input register is empty or the result register is empty or taken.
module bitbang_fpga_command_port #(
  parameter int unsigned PARAM_ROM_DEPTH = bbfcp_pkg::PARAM_ROM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // is_pin_data_register, clock_before, clock_now, read_write_pin, bus_byte[7:0]
  input  logic [15:0] s_axis_tdata,
  // data_command_pin
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // returned_byte[7:0]
  output logic [7:0]  m_axis_tdata
);

  logic             in_valid_q;
  bbfcp_pkg::item_t in_q;
  logic             out_valid_q;
  logic [7:0]       out_data_q;
  logic             step;
  logic             fire;
  logic [7:0]       result;

  assign step          = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & step;
  assign s_axis_tready = ~in_valid_q | step;

  bbfcp_core #(
    .PARAM_ROM_DEPTH(PARAM_ROM_DEPTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (step) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.is_pin_data_register <= s_axis_tdata[0];
      in_q.clock_before         <= s_axis_tdata[1];
      in_q.clock_now            <= s_axis_tdata[2];
      in_q.read_write_pin       <= s_axis_tdata[3];
      in_q.bus_byte             <= s_axis_tdata[11:4];
      in_q.data_command_pin     <= s_axis_tuser;
    end
    if (fire) out_data_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[sv/bbfcp_param_step.sv]
module bbfcp_param_step #(
  parameter int unsigned PARAM_ROM_DEPTH = bbfcp_pkg::PARAM_ROM_DEPTH_DEF
) (
  input  logic [7:0]         last_cmd_i,
  input  logic [7:0]         start_i,
  input  logic [7:0]         key_i,
  input  logic [7:0]         offset_i,
  input  logic [6:0][7:0]    pbuf_i,
  output bbfcp_pkg::param_upd_t upd_o
);

  localparam logic [8:0] DEPTH9 = 9'(PARAM_ROM_DEPTH);

  // offset reduced modulo the rom depth, a constant table
  logic [7:0] mod_tbl [256];
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = 8'(g % PARAM_ROM_DEPTH);
  end

  logic [7:0]      base;
  logic [3:0][7:0] fetched;
  logic [8:0]      addr;
  logic [7:0]      nkey;
  logic [7:0]      tag;
  logic [7:0]      csum;

  always_comb begin
    base = mod_tbl[offset_i];
    for (int k = 0; k < 4; k++) begin
      addr = {1'b0, base} + 9'(k);
      if (addr >= DEPTH9) addr = addr - DEPTH9;
      fetched[k] = bbfcp_pkg::rom_byte(addr[7:0]);
    end
    nkey = ~key_i;
    priority if (fetched[0] != 8'h00) tag = bbfcp_pkg::TAG_B3;
    else if (fetched[1] != 8'h00)     tag = bbfcp_pkg::TAG_B4;
    else if (fetched[2] != 8'h00)     tag = bbfcp_pkg::TAG_B5;
    else                              tag = bbfcp_pkg::TAG_NONE;
    csum = nkey + tag + fetched[0] + fetched[1] + fetched[2] + fetched[3];

    upd_o.key    = key_i;
    upd_o.offset = offset_i;
    upd_o.pbuf   = pbuf_i;
    upd_o.start  = 8'h01;
    if (last_cmd_i == bbfcp_pkg::CMD_PARAM_READ) begin
      if (start_i == 8'h00) begin
        upd_o.key     = 8'h00;
        upd_o.offset  = 8'h00;
        upd_o.pbuf[3] = 8'h00;
      end else begin
        upd_o.key     = nkey;
        upd_o.pbuf[0] = key_i;
        upd_o.pbuf[1] = tag ^ nkey;
        upd_o.pbuf[2] = csum ^ nkey;
        upd_o.pbuf[3] = fetched[0] ^ nkey;
        upd_o.pbuf[4] = fetched[1] ^ nkey;
        upd_o.pbuf[5] = fetched[2] ^ nkey;
        upd_o.pbuf[6] = fetched[3] ^ nkey;
      end
    end else if (last_cmd_i == bbfcp_pkg::CMD_PARAM_SEEK) begin
      upd_o.offset = pbuf_i[1] ^ key_i;
    end
  end

endmodule

[sv/bbfcp_core.sv]
module bbfcp_core #(
  parameter int unsigned PARAM_ROM_DEPTH = bbfcp_pkg::PARAM_ROM_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  bbfcp_pkg::item_t item_i,
  output logic [7:0]       result_o
);

  typedef enum logic [1:0] {
    XM_READ  = 2'd0,
    XM_WRITE = 2'd1,
    XM_CMD   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    TG_NONE    = 3'd0,
    TG_VERSION = 3'd1,
    TG_STATUS  = 3'd2,
    TG_BRIGHT  = 3'd3,
    TG_TOUCH   = 3'd4,
    TG_START   = 3'd5,
    TG_PARAM   = 3'd6
  } target_e;

  mode_e           mode_q, mode_d;
  logic [7:0]      last_q, last_d;
  target_e         sel_q, sel_d;
  logic [2:0]      idx_q, idx_d;
  logic [1:0]      left_q, left_d;
  logic [1:0][7:0] version_q, version_d;
  logic [1:0][7:0] status_q, status_d;
  logic [1:0][7:0] bright_q, bright_d;
  logic [1:0][7:0] touch_q, touch_d;
  logic [6:0][7:0] pbuf_q, pbuf_d;
  logic [7:0]      key_q, key_d;
  logic [7:0]      offset_q, offset_d;
  logic [7:0]      start_q, start_d;

  bbfcp_pkg::param_upd_t upd;

  bbfcp_param_step #(
    .PARAM_ROM_DEPTH(PARAM_ROM_DEPTH)
  ) u_param_step (
    .last_cmd_i(last_q),
    .start_i   (start_q),
    .key_i     (key_q),
    .offset_i  (offset_q),
    .pbuf_i    (pbuf_q),
    .upd_o     (upd)
  );

  logic       rising;
  logic       cell_ok;
  logic [7:0] cell_rd;
  logic [7:0] b;
  logic       advance;

  always_comb begin
    rising = item_i.is_pin_data_register & ~item_i.clock_before & item_i.clock_now;
    cell_ok = 1'b1;
    cell_rd = 8'h00;
    unique case (sel_q)
      TG_VERSION: cell_rd = version_q[idx_q[0]];
      TG_STATUS:  cell_rd = status_q[idx_q[0]];
      TG_BRIGHT:  cell_rd = bright_q[idx_q[0]];
      TG_TOUCH:   cell_rd = touch_q[idx_q[0]];
      TG_START:   cell_rd = start_q;
      TG_PARAM: begin
        cell_ok = (idx_q != 3'd7);
        cell_rd = cell_ok ? pbuf_q[idx_q] : 8'h00;
      end
      default:    cell_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    last_d    = last_q;
    sel_d     = sel_q;
    idx_d     = idx_q;
    left_d    = left_q;
    version_d = version_q;
    status_d  = status_q;
    bright_d  = bright_q;
    touch_d   = touch_q;
    pbuf_d    = pbuf_q;
    key_d     = key_q;
    offset_d  = offset_q;
    start_d   = start_q;
    b         = item_i.bus_byte;
    advance   = 1'b0;

    if (rising) begin
      if (item_i.data_command_pin && item_i.read_write_pin) begin
        mode_d = XM_CMD;
        sel_d  = TG_NONE;
        idx_d  = 3'd0;
        left_d = 2'd0;
        unique case (item_i.bus_byte)
          bbfcp_pkg::CMD_VERSION: begin sel_d = TG_VERSION; left_d = 2'd2; end
          bbfcp_pkg::CMD_STATUS:  begin sel_d = TG_STATUS;  left_d = 2'd2; end
          bbfcp_pkg::CMD_CH_A_IN: b = bbfcp_pkg::CMD_CH_A_OUT;
          bbfcp_pkg::CMD_CH_B_IN: b = bbfcp_pkg::CMD_CH_B_OUT;
          bbfcp_pkg::CMD_BRIGHT:  begin sel_d = TG_BRIGHT;  left_d = 2'd2; end
          bbfcp_pkg::CMD_TOUCH:   begin sel_d = TG_TOUCH;   left_d = 2'd2; end
          bbfcp_pkg::CMD_PARAM_STEP: begin
            key_d    = upd.key;
            offset_d = upd.offset;
            pbuf_d   = upd.pbuf;
            start_d  = upd.start;
          end
          bbfcp_pkg::CMD_START_A, bbfcp_pkg::CMD_START_B: begin
            if (last_q == bbfcp_pkg::CMD_PARAM_STEP) begin
              sel_d  = TG_START;
              left_d = 2'd1;
            end
          end
          default: begin
            // single parameter byte, picked by the low code bits
            if (item_i.bus_byte >= bbfcp_pkg::CMD_PARAM_FIRST &&
                item_i.bus_byte <= bbfcp_pkg::CMD_PARAM_LAST &&
                last_q == bbfcp_pkg::CMD_START_B) begin
              sel_d  = TG_PARAM;
              idx_d  = item_i.bus_byte[2:0];
              left_d = 2'd1;
            end
          end
        endcase
        last_d = b;
      end else if (!item_i.data_command_pin && item_i.read_write_pin) begin
        if (mode_q != XM_READ) begin
          mode_d = XM_WRITE;
          if (cell_ok) begin
            advance = 1'b1;
            unique case (sel_q)
              TG_VERSION: version_d[idx_q[0]] = b;
              TG_STATUS:  status_d[idx_q[0]]  = b;
              TG_BRIGHT:  bright_d[idx_q[0]]  = b;
              TG_TOUCH:   touch_d[idx_q[0]]   = b;
              TG_START:   start_d             = b;
              TG_PARAM:   pbuf_d[idx_q]       = b;
              default:    advance = 1'b0;
            endcase
          end
        end
      end else if (!item_i.data_command_pin && !item_i.read_write_pin) begin
        if (mode_q == XM_WRITE) begin
          b = bbfcp_pkg::READ_AFTER_WRITE;
        end else begin
          mode_d = XM_READ;
          if (cell_ok) begin
            b       = cell_rd;
            advance = 1'b1;
          end
        end
      end
    end

    // drop the target after its last byte
    if (advance && left_q != 2'd0) begin
      left_d = left_q - 2'd1;
      if (left_q != 2'd1) idx_d = idx_q + 3'd1;
      else sel_d = TG_NONE;
    end
  end

  assign result_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= XM_READ;
      last_q    <= 8'h00;
      sel_q     <= TG_NONE;
      idx_q     <= 3'd0;
      left_q    <= 2'd0;
      version_q <= bbfcp_pkg::VERSION_RST;
      status_q  <= bbfcp_pkg::STATUS_RST;
      bright_q  <= '0;
      touch_q   <= '0;
      pbuf_q    <= '0;
      key_q     <= 8'h00;
      offset_q  <= 8'h00;
      start_q   <= 8'h00;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      last_q    <= last_d;
      sel_q     <= sel_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      version_q <= version_d;
      status_q  <= status_d;
      bright_q  <= bright_d;
      touch_q   <= touch_d;
      pbuf_q    <= pbuf_d;
      key_q     <= key_d;
      offset_q  <= offset_d;
      start_q   <= start_d;
    end
  end

endmodule

[sv/bbfcp_checker.sv]
`include "bitbang_fpga_command_port_assert.svh"

module bbfcp_port_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic       s_take;
  logic       s_pass;
  logic [7:0] s_byte;
  logic       m_stall;

  assign s_take  = s_axis_tvalid & s_axis_tready;
  assign s_pass  = s_take & ~s_axis_tdata[0];
  assign s_byte  = s_axis_tdata[11:4];
  assign m_stall = m_axis_tvalid & ~m_axis_tready;

  `BBFCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid, "result dropped")
  `BBFCP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_stall, $stable(m_axis_tdata), "result changed")
  `BBFCP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input blocked")
  `BBFCP_ASSERT(a_latency, clk_i, rst_ni, (s_take ##1 m_axis_tready) |=> m_axis_tvalid, "item lost")
  // an item that is not a write to the pin data register comes back unchanged
  `BBFCP_ASSERT(a_passthru, clk_i, rst_ni,
                (s_pass ##1 m_axis_tready) |=> (m_axis_tdata == $past(s_byte, 2)),
                "idle item was altered")

endmodule

bind bitbang_fpga_command_port bbfcp_port_assert u_bbfcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
